// ===== hw/rtl/alu16_pkg.sv =====
`default_nettype none
package alu16_pkg;

  typedef enum logic [3:0] {
    OP_ADDS = 4'd0,
    OP_ADD  = 4'd1,
    OP_ADC  = 4'd2,
    OP_SUB  = 4'd3,
    OP_SBC  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_XOR  = 4'd7,
    OP_CADD = 4'd8,
    OP_ROR  = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    CC_Z   = 4'd0,
    CC_NZ  = 4'd1,
    CC_C   = 4'd2,
    CC_NC  = 4'd3,
    CC_S   = 4'd4,
    CC_NS  = 4'd5,
    CC_V   = 4'd6,
    CC_NV  = 4'd7,
    CC_HI  = 4'd8,
    CC_LS  = 4'd9,
    CC_GE  = 4'd10,
    CC_LT  = 4'd11,
    CC_GT  = 4'd12,
    CC_LE  = 4'd13
  } cond_t;

  typedef enum logic [1:0] {
    K_PASS  = 2'd0,
    K_ARITH = 2'd1,
    K_LOGIC = 2'd2,
    K_ROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic c;
    logic z;
    logic s;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] x;
    logic [15:0] y;
    flags_t      flags;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    op_t         lop;
    logic        sub;
    logic [15:0] a;
    logic [15:0] b;
    logic        cin;
    logic [3:0]  amt;
    flags_t      flags;
  } s1_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] r;
    logic        c_new;
    logic        a15;
    logic        b15;
    flags_t      flags;
  } s2_t;

  typedef struct packed {
    logic [15:0] r;
    flags_t      flags;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/alu16_dec.sv =====
`default_nettype none
module alu16_dec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                valid_i,
  input  wire alu16_pkg::in_item_t item_i,
  input  wire logic                rdy_i,
  output logic                     rdy_o,
  output logic                     valid_o,
  output alu16_pkg::s1_t           s1_o
);
  import alu16_pkg::*;

  logic  vld_r;
  s1_t   s1_r;
  s1_t   s1_nxt;
  logic  pass;
  op_t   op;
  cond_t cc;
  flags_t f;

  assign rdy_o   = !vld_r || rdy_i;
  assign valid_o = vld_r;
  assign s1_o    = s1_r;

  always_comb begin
    op = op_t'(item_i.mode);
    cc = cond_t'(item_i.x[15:12]);
    f  = item_i.flags;
    unique case (cc)
      CC_Z:    pass = f.z;
      CC_NZ:   pass = !f.z;
      CC_C:    pass = f.c;
      CC_NC:   pass = !f.c;
      CC_S:    pass = f.s;
      CC_NS:   pass = !f.s;
      CC_V:    pass = f.v;
      CC_NV:   pass = !f.v;
      CC_HI:   pass = !f.c && !f.z;
      CC_LS:   pass = f.c || f.z;
      CC_GE:   pass = f.s == f.v;
      CC_LT:   pass = f.s != f.v;
      CC_GT:   pass = !f.z && (f.s == f.v);
      CC_LE:   pass = f.z || (f.s != f.v);
      default: pass = 1'b0;
    endcase

    s1_nxt.kind  = K_PASS;
    s1_nxt.lop   = op;
    s1_nxt.sub   = 1'b0;
    s1_nxt.a     = item_i.y;
    s1_nxt.b     = 16'd0;
    s1_nxt.cin   = 1'b0;
    s1_nxt.amt   = item_i.x[3:0];
    s1_nxt.flags = f;
    unique case (op)
      OP_ADDS: s1_nxt.b = item_i.x;
      OP_ADD, OP_ADC: begin
        s1_nxt.kind = K_ARITH;
        s1_nxt.b    = item_i.x;
        s1_nxt.cin  = (op == OP_ADC) ? f.c : 1'b0;
      end
      OP_SUB, OP_SBC: begin
        s1_nxt.kind = K_ARITH;
        s1_nxt.sub  = 1'b1;
        s1_nxt.b    = ~item_i.x;
        s1_nxt.cin  = (op == OP_SBC) ? !f.c : 1'b1;
      end
      OP_AND, OP_OR, OP_XOR: begin
        s1_nxt.kind = K_LOGIC;
        s1_nxt.b    = item_i.x;
      end
      OP_CADD: s1_nxt.b = pass ? {{4{item_i.x[11]}}, item_i.x[11:0]} : 16'd0;
      OP_ROR:  s1_nxt.kind = K_ROR;
      default: s1_nxt.b = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/alu16_exe.sv =====
`default_nettype none
module alu16_exe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           valid_i,
  input  wire alu16_pkg::s1_t s1_i,
  input  wire logic           rdy_i,
  output logic                rdy_o,
  output logic                valid_o,
  output alu16_pkg::s2_t      s2_o
);
  import alu16_pkg::*;

  logic        vld_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  logic [16:0] sum;
  logic [31:0] dbl;
  logic [3:0]  bidx;
  logic [15:0] lres;

  assign rdy_o   = !vld_r || rdy_i;
  assign valid_o = vld_r;
  assign s2_o    = s2_r;

  always_comb begin
    sum  = {1'b0, s1_i.a} + {1'b0, s1_i.b} + {16'd0, s1_i.cin};
    dbl  = {s1_i.a, s1_i.a} >> s1_i.amt;
    bidx = s1_i.amt - 4'd1;
    unique case (s1_i.lop)
      OP_AND:  lres = s1_i.a & s1_i.b;
      OP_OR:   lres = s1_i.a | s1_i.b;
      default: lres = s1_i.a ^ s1_i.b;
    endcase

    s2_nxt.kind  = s1_i.kind;
    s2_nxt.a15   = s1_i.a[15];
    s2_nxt.b15   = s1_i.b[15];
    s2_nxt.flags = s1_i.flags;
    unique case (s1_i.kind)
      K_PASS: begin
        s2_nxt.r     = sum[15:0];
        s2_nxt.c_new = 1'b0;
      end
      K_ARITH: begin
        s2_nxt.r     = sum[15:0];
        s2_nxt.c_new = s1_i.sub ? !sum[16] : sum[16];
      end
      K_LOGIC: begin
        s2_nxt.r     = lres;
        s2_nxt.c_new = 1'b0;
      end
      K_ROR: begin
        s2_nxt.r     = dbl[15:0];
        s2_nxt.c_new = (s1_i.amt == 4'd0) ? 1'b0 : s1_i.a[bidx];
      end
      default: begin
        s2_nxt.r     = s1_i.a;
        s2_nxt.c_new = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/alu16_flg.sv =====
`default_nettype none
module alu16_flg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           valid_i,
  input  wire alu16_pkg::s2_t s2_i,
  input  wire logic           rdy_i,
  output logic                rdy_o,
  output logic                valid_o,
  output alu16_pkg::out_item_t item_o
);
  import alu16_pkg::*;

  logic      vld_r;
  out_item_t item_r;
  out_item_t item_nxt;
  logic      zr;
  logic      ovf;

  assign rdy_o   = !vld_r || rdy_i;
  assign valid_o = vld_r;
  assign item_o  = item_r;

  always_comb begin
    zr  = (s2_i.r == 16'd0);
    ovf = (!s2_i.a15 && !s2_i.b15 && s2_i.r[15]) || (s2_i.a15 && s2_i.b15 && !s2_i.r[15]);
    item_nxt.r = s2_i.r;
    unique case (s2_i.kind)
      K_PASS: item_nxt.flags = s2_i.flags;
      K_ARITH: begin
        item_nxt.flags.c = s2_i.c_new;
        item_nxt.flags.z = zr;
        item_nxt.flags.s = s2_i.r[15];
        item_nxt.flags.v = ovf;
      end
      K_LOGIC, K_ROR: begin
        item_nxt.flags.c = s2_i.c_new;
        item_nxt.flags.z = zr;
        item_nxt.flags.s = s2_i.r[15];
        item_nxt.flags.v = 1'b0;
      end
      default: item_nxt.flags = s2_i.flags;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cpu16_alu_with_flags.sv =====
// 16-bit ALU with carry, zero, sign and overflow flags.
// Input channel: in_valid / in_stall with mode, operands x and y and the four
// current flags. Result channel: out_valid / out_stall with the 16-bit result
// and the four new flags. One result item per input item, in order.
// Pipeline: decode (operand prep and condition test), execute (adder, logic,
// rotator), flags (zero, sign, overflow select and output register).
// Each accepted item is registered in the decode, execute and flags stages in
// turn; out_valid rises once the flags stage holds it.
// Throughput: one item per cycle while out_stall is low; the single 17-bit adder
// in the execute stage sets the cycle.
// Reset (synchronous, rst_n low) clears all stage valid bits; the pipeline
// comes up empty and ready.
// When the receiver stalls, the output item holds and each stage keeps its
// item once the stage after it is full; in_stall rises only when all three
// stages hold items. Empty stages keep filling during a stall.
`default_nettype none
module cpu16_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_mode,
  input  wire logic [15:0] in_operand_x,
  input  wire logic [15:0] in_operand_y,
  input  wire logic        in_carry_in,
  input  wire logic        in_zero_in,
  input  wire logic        in_sign_in,
  input  wire logic        in_overflow_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_result,
  output logic             out_carry_out,
  output logic             out_zero_out,
  output logic             out_sign_out,
  output logic             out_overflow_out
);
  import alu16_pkg::*;

  in_item_t  item_in;
  s1_t       s1;
  s2_t       s2;
  out_item_t item_out;
  logic      v1;
  logic      v2;
  logic      rdy1;
  logic      rdy2;
  logic      rdy3;

  assign item_in.mode    = in_mode;
  assign item_in.x       = in_operand_x;
  assign item_in.y       = in_operand_y;
  assign item_in.flags.c = in_carry_in;
  assign item_in.flags.z = in_zero_in;
  assign item_in.flags.s = in_sign_in;
  assign item_in.flags.v = in_overflow_in;

  alu16_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .item_i  (item_in),
    .rdy_i   (rdy2),
    .rdy_o   (rdy1),
    .valid_o (v1),
    .s1_o    (s1)
  );

  alu16_exe u_exe (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v1),
    .s1_i    (s1),
    .rdy_i   (rdy3),
    .rdy_o   (rdy2),
    .valid_o (v2),
    .s2_o    (s2)
  );

  alu16_flg u_flg (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v2),
    .s2_i    (s2),
    .rdy_i   (!out_stall),
    .rdy_o   (rdy3),
    .valid_o (out_valid),
    .item_o  (item_out)
  );

  assign in_stall         = !rdy1;
  assign out_result       = item_out.r;
  assign out_carry_out    = item_out.flags.c;
  assign out_zero_out     = item_out.flags.z;
  assign out_sign_out     = item_out.flags.s;
  assign out_overflow_out = item_out.flags.v;

endmodule
`default_nettype wire

// ===== hw/rtl/alu16_chk.sv =====
`default_nettype none
module alu16_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_result,
  input wire logic        out_carry_out,
  input wire logic        out_zero_out,
  input wire logic        out_sign_out,
  input wire logic        out_overflow_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while receiver takes items");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item did not reach output in three cycles");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result)
      && $stable(out_carry_out) && $stable(out_zero_out)
      && $stable(out_sign_out) && $stable(out_overflow_out)))
    else $error("stalled output item changed");

endmodule

bind cpu16_alu_with_flags alu16_chk u_chk (.*);
`default_nettype wire

// ===== verif/alu_result_checker.sv =====
module alu_result_checker
  import alu16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [3:0]  in_mode,
  input  wire logic [15:0] in_operand_x,
  input  wire logic [15:0] in_operand_y,
  input  wire logic        in_carry_in,
  input  wire logic        in_zero_in,
  input  wire logic        in_sign_in,
  input  wire logic        in_overflow_in,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_result,
  input  wire logic        out_carry_out,
  input  wire logic        out_zero_out,
  input  wire logic        out_sign_out,
  input  wire logic        out_overflow_out,
  output int               fail_count,
  output int               pending,
  output int               results_checked
);

  out_item_t pending_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
    results_checked = 0;
  end

  function automatic logic cond_taken(logic [3:0] code, flags_t f);
    case (code)
      CC_Z:    return f.z;
      CC_NZ:   return !f.z;
      CC_C:    return f.c;
      CC_NC:   return !f.c;
      CC_S:    return f.s;
      CC_NS:   return !f.s;
      CC_V:    return f.v;
      CC_NV:   return !f.v;
      CC_HI:   return !f.c && !f.z;
      CC_LS:   return f.c || f.z;
      CC_GE:   return f.s == f.v;
      CC_LT:   return f.s != f.v;
      CC_GT:   return !f.z && (f.s == f.v);
      CC_LE:   return f.z || (f.s != f.v);
      default: return 1'b0;
    endcase
  endfunction

  function automatic out_item_t alu_compute(logic [3:0] mode, logic [15:0] x, logic [15:0] y,
                                            flags_t f);
    logic [16:0] wide;
    logic [15:0] r;
    logic [15:0] offset;
    logic [3:0]  amount;
    flags_t      nf;
    nf = f;
    r = y;
    case (mode)
      OP_ADDS: begin
        r = y + x;
      end
      OP_ADD, OP_ADC: begin
        wide = {1'b0, y} + {1'b0, x} + ((mode == OP_ADC) ? {16'd0, f.c} : 17'd0);
        r = wide[15:0];
        nf.c = wide[16];
        nf.v = (y[15] == x[15]) && (r[15] != y[15]);
      end
      OP_SUB, OP_SBC: begin
        wide = {1'b0, y} - {1'b0, x} - ((mode == OP_SBC) ? {16'd0, f.c} : 17'd0);
        r = wide[15:0];
        nf.c = wide[16];
        nf.v = (y[15] != x[15]) && (r[15] != y[15]);
      end
      OP_AND, OP_OR, OP_XOR: begin
        r = (mode == OP_AND) ? (x & y) : (mode == OP_OR) ? (x | y) : (x ^ y);
        nf.c = 1'b0;
        nf.v = 1'b0;
      end
      OP_CADD: begin
        offset = {{4{x[11]}}, x[11:0]};
        if (cond_taken(x[15:12], f)) begin
          r = y + offset;
        end
      end
      OP_ROR: begin
        amount = x[3:0];
        if (amount == 4'd0) begin
          nf.c = 1'b0;
        end else begin
          r = (y >> amount) | (y << (5'd16 - {1'b0, amount}));
          nf.c = y[amount - 4'd1];
        end
        nf.v = 1'b0;
      end
      default: begin
      end
    endcase
    if (mode inside {OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_OR, OP_XOR, OP_ROR}) begin
      nf.z = (r == 16'd0);
      nf.s = r[15];
    end
    return '{r: r, flags: nf};
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(alu_compute(in_mode, in_operand_x, in_operand_y,
            flags_t'({in_carry_in, in_zero_in, in_sign_in, in_overflow_in})));
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: result %h", out_result);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("result", want.r, out_result);
          check_field("carry_out", 16'(want.flags.c), 16'(out_carry_out));
          check_field("zero_out", 16'(want.flags.z), 16'(out_zero_out));
          check_field("sign_out", 16'(want.flags.s), 16'(out_sign_out));
          check_field("overflow_out", 16'(want.flags.v), 16'(out_overflow_out));
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import alu16_pkg::*;

  localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam logic [3:0] CC_NEVER_LO    = 4'd14;
  localparam logic [3:0] CC_NEVER_HI    = 4'd15;
  localparam int         RANDOM_OPS     = 400;
  localparam int         QUIET_LIMIT    = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_mode = '0;
  logic [15:0] in_operand_x = '0;
  logic [15:0] in_operand_y = '0;
  logic        in_carry_in = 1'b0;
  logic        in_zero_in = 1'b0;
  logic        in_sign_in = 1'b0;
  logic        in_overflow_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_result;
  logic        out_carry_out;
  logic        out_zero_out;
  logic        out_sign_out;
  logic        out_overflow_out;

  logic idle_on = 1'b1;
  int   fail_count;
  int   pending;
  int   results_checked;
  int   ops_sent = 0;
  int   quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  cpu16_alu_with_flags DUT (.*);

  alu_result_checker u_checker (.*);

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[cpu16_alu_with_flags] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // flags packed as {carry, zero, sign, overflow}
  task automatic push_op(input logic [3:0] mode, input logic [15:0] x, input logic [15:0] y,
                         input logic [3:0] flags);
    while (idle_on && ($urandom_range(99) < 15)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_operand_x <= x;
    in_operand_y <= y;
    {in_carry_in, in_zero_in, in_sign_in, in_overflow_in} <= flags;
    do @(posedge clk); while (in_stall);
    ops_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] mode;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_op(OP_ADDS, 16'h0001, 16'hFFFF, 4'b1111);
    push_op(OP_ADD,  16'h0001, 16'h7FFF, 4'b0000);
    push_op(OP_ADD,  16'hFFFF, 16'hFFFF, 4'b0000);
    push_op(OP_ADC,  16'h0000, 16'hFFFF, 4'b1000);
    push_op(OP_ADD,  16'h8000, 16'h8000, 4'b0000);
    push_op(OP_SUB,  16'h0001, 16'h0000, 4'b0000);
    push_op(OP_SUB,  16'h0001, 16'h8000, 4'b0000);
    push_op(OP_SBC,  16'hFFFF, 16'h0000, 4'b1000);
    push_op(OP_SBC,  16'h0005, 16'h0005, 4'b0000);
    push_op(OP_AND,  16'h0000, 16'hFFFF, 4'b1111);
    push_op(OP_OR,   16'h0001, 16'h8000, 4'b1001);
    push_op(OP_XOR,  16'hFFFF, 16'hFFFF, 4'b1001);
    push_op(OP_CADD, {CC_Z, 12'h800}, 16'h0000, 4'b0100);
    push_op(OP_CADD, {CC_Z, 12'h7FF}, 16'hFFFF, 4'b0000);
    push_op(OP_CADD, {CC_LE, 12'hFFF}, 16'h1234, 4'b0010);
    push_op(OP_CADD, {CC_NEVER_LO, 12'h001}, 16'h1234, 4'b1111);
    push_op(OP_CADD, {CC_NEVER_HI, 12'h001}, 16'h1234, 4'b0000);
    push_op(OP_ROR,  16'h0000, 16'h8001, 4'b1001);
    push_op(OP_ROR,  16'h0001, 16'h0001, 4'b0000);
    push_op(OP_ROR,  16'hFFFF, 16'h8000, 4'b0000);
    push_op(OP_ROR,  16'hFFF0, 16'h0000, 4'b1111);
    push_op(MODE_UNUSED_LO, 16'hFFFF, 16'hA5A5, 4'b1010);
    push_op(MODE_UNUSED_HI, 16'h0000, 16'h5A5A, 4'b0101);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 150) idle_on <= 1'b0;
      if (i == 250) idle_on <= 1'b1;
      if ($urandom_range(99) < 5) begin
        mode = 4'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      end else begin
        mode = 4'($urandom_range(OP_ROR, OP_ADDS));
      end
      push_op(mode, pick_word(), pick_word(), 4'($urandom));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d operations: flag and condition corners, then a random mix", ops_sent);
    $display("of all modes incl. unused codes under random stalls; %0d results compared",
             results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[cpu16_alu_with_flags] OK");
    end else begin
      $display("[cpu16_alu_with_flags] ERROR");
    end
    $finish;
  end

endmodule
